/* hdl/uart_receive_line_assembler_core_assert.svh */
// -----------------------------------------------------------------------------
// uart_receive_line_assembler_core assertion macros
// Shared concurrent assertion forms for the line assembler checkers.
// -----------------------------------------------------------------------------
`ifndef UART_RECEIVE_LINE_ASSEMBLER_CORE_ASSERT_SVH
`define UART_RECEIVE_LINE_ASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define URLA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define URLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/urla_pkg.sv */
// -----------------------------------------------------------------------------
// urla_pkg
// Constants and controller/datapath interface types of the line assembler.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urla_pkg;

  localparam int LINE_BYTES = 32;
  localparam int AddrW      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CountW     = $clog2(LINE_BYTES + 1);
  localparam int CharW      = 8;
  localparam int LenW       = 6;

  localparam logic [CharW-1:0] CharCr = 8'h0D;
  localparam logic [CharW-1:0] CharLf = 8'h0A;

  typedef struct packed {
    logic store_byte;   // write incoming word at fill count
    logic start_flush;  // latch incoming word, clear read index
    logic rd_en;        // read store at read index
    logic idx_inc;      // advance read index
    logic finish;       // end of flush, restart line
  } ctrl_cmd_t;

  typedef struct packed {
    logic enabled;
    logic is_cr;
    logic is_lf;
    logic full;
    logic count_zero;
    logic last;
  } dp_status_t;

endpackage

/* hdl/urla_ctrl.sv */
// -----------------------------------------------------------------------------
// urla_ctrl
// Sequencer for the line assembler: byte intake, flush walk, output handshake.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urla_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_byte_valid_i,
  output logic                  rx_byte_ready_o,
  output logic                  line_valid_o,
  input  logic                  line_ready_i,
  input  urla_pkg::dp_status_t  status_i,
  output urla_pkg::ctrl_cmd_t   cmd_o
);
  import urla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    rx_byte_ready_o = 1'b0;
    line_valid_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        rx_byte_ready_o = 1'b1;
        if (rx_byte_valid_i && status_i.enabled && !status_i.is_cr) begin
          if (status_i.is_lf || status_i.full) begin
            cmd_o.start_flush = 1'b1;
            state_d = status_i.count_zero ? S_OUT : S_READ;
          end else begin
            cmd_o.store_byte = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        line_valid_o = 1'b1;
        if (line_ready_i) begin
          if (status_i.last) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/urla_datapath.sv */
// -----------------------------------------------------------------------------
// urla_datapath
// Line store, fill count, read index, held word and result fields.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urla_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_enable_we_i,
  input  logic                          rx_enable_wdata_i,
  input  logic [urla_pkg::CharW-1:0]    rx_byte_i,
  input  urla_pkg::ctrl_cmd_t           cmd_i,
  output urla_pkg::dp_status_t          status_o,
  output logic [urla_pkg::CharW-1:0]    line_char_o,
  output logic [urla_pkg::LenW-1:0]     line_length_o,
  output logic                          last_of_line_o,
  output logic                          empty_line_o
);
  import urla_pkg::*;

  logic [CharW-1:0]  store_mem [LINE_BYTES];
  logic [CharW-1:0]  rd_q;
  logic              rx_enable_q;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              empty_q;
  logic [CharW-1:0]  pend_q;
  logic              pend_lf_q;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CharW-1:0]  wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q <= 1'b0;
    end else if (rx_enable_we_i) begin
      rx_enable_q <= rx_enable_wdata_i;
    end
  end

  // one write port: intake at fill count, or carried word at entry 0
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rx_byte_i;
    if (cmd_i.store_byte) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AddrW-1:0];
    end else if (cmd_i.finish && !pend_lf_q) begin
      wr_en   = 1'b1;
      wr_data = pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= store_mem[idx_q];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.store_byte) begin
      count_d = count_q + CountW'(1);
    end else if (cmd_i.finish) begin
      count_d = pend_lf_q ? '0 : CountW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start_flush) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.start_flush) begin
        empty_q <= (count_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_flush) begin
      pend_q    <= rx_byte_i;
      pend_lf_q <= (rx_byte_i == CharLf);
    end
  end

  assign status_o.enabled    = rx_enable_q;
  assign status_o.is_cr      = (rx_byte_i == CharCr);
  assign status_o.is_lf      = (rx_byte_i == CharLf);
  assign status_o.full       = (count_q >= CountW'(LINE_BYTES));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.last       = last_of_line_o;

  assign line_char_o    = empty_q ? '0 : rd_q;
  assign line_length_o  = LenW'(count_q);
  assign last_of_line_o = empty_q || ((CountW'(idx_q) + CountW'(1)) == count_q);
  assign empty_line_o   = empty_q;

endmodule

/* hdl/uart_receive_line_assembler_core.sv */
// -----------------------------------------------------------------------------
// uart_receive_line_assembler_core
// Gathers received serial bytes into lines and flushes each line as words.
// -----------------------------------------------------------------------------
// channel   direction  handshake                          payload
// rx_byte   in         rx_byte_valid_i / rx_byte_ready_o  rx_byte_i
// line      out        line_valid_o / line_ready_i        line_char_o, line_length_o,
//                                                         last_of_line_o, empty_line_o
// config    in         rx_enable_we_i                     rx_enable_wdata_i
//
// An ordinary byte is taken with a single write to the line store.
// A flush emits each word through a store read, then an output hold that
// lasts until line_ready_i, so each word is accepted before the next is read;
// an empty line skips the store read. No input word is taken during a flush.
// Reset clears the fill count, enable and controller; the store needs none.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_receive_line_assembler_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rx_enable_we_i,
  input  logic                       rx_enable_wdata_i,
  input  logic                       rx_byte_valid_i,
  output logic                       rx_byte_ready_o,
  input  logic [urla_pkg::CharW-1:0] rx_byte_i,
  output logic                       line_valid_o,
  input  logic                       line_ready_i,
  output logic [urla_pkg::CharW-1:0] line_char_o,
  output logic [urla_pkg::LenW-1:0]  line_length_o,
  output logic                       last_of_line_o,
  output logic                       empty_line_o
);
  import urla_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  urla_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_valid_i (rx_byte_valid_i),
    .rx_byte_ready_o (rx_byte_ready_o),
    .line_valid_o    (line_valid_o),
    .line_ready_i    (line_ready_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  urla_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_enable_we_i    (rx_enable_we_i),
    .rx_enable_wdata_i (rx_enable_wdata_i),
    .rx_byte_i         (rx_byte_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .line_char_o       (line_char_o),
    .line_length_o     (line_length_o),
    .last_of_line_o    (last_of_line_o),
    .empty_line_o      (empty_line_o)
  );

endmodule

/* hdl/urla_checker.sv */
// -----------------------------------------------------------------------------
// urla_checker
// Port-level checks of the line assembler, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_receive_line_assembler_core_assert.svh"

module urla_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rx_byte_ready_o,
  input logic                       line_valid_o,
  input logic                       line_ready_i,
  input logic [urla_pkg::CharW-1:0] line_char_o,
  input logic [urla_pkg::LenW-1:0]  line_length_o,
  input logic                       last_of_line_o,
  input logic                       empty_line_o
);
  import urla_pkg::*;

  `URLA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, line_valid_o && !line_ready_i, line_valid_o && $stable(line_char_o) && $stable(last_of_line_o), "line word changed while stalled")
  `URLA_ASSERT_IMPL(a_empty_form, clk_i, rst_ni, line_valid_o && empty_line_o, last_of_line_o && (line_char_o == '0) && (line_length_o == '0), "malformed empty line word")
  `URLA_ASSERT_IMPL(a_len_nonzero, clk_i, rst_ni, line_valid_o && !empty_line_o, line_length_o != '0, "zero length on a non-empty line")
  `URLA_ASSERT_IMPL(a_no_intake_in_flush, clk_i, rst_ni, line_valid_o, !rx_byte_ready_o, "input ready during a flush")

endmodule

bind uart_receive_line_assembler_core urla_checker u_urla_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_byte_ready_o (rx_byte_ready_o),
  .line_valid_o    (line_valid_o),
  .line_ready_i    (line_ready_i),
  .line_char_o     (line_char_o),
  .line_length_o   (line_length_o),
  .last_of_line_o  (last_of_line_o),
  .empty_line_o    (empty_line_o)
);
